/* rtl/core/bhist_pkg.sv */
// ============================================================================
// Bucketed latency histogram package
// Shared types, constants and the saturating adder used by the histogram.
// ============================================================================
package bhist_pkg;

    // Leaves of the cumulative adder tree; buckets past the configured
    // count read as zero.
    localparam int MAX_BUCKETS = 8;
    localparam int PART_COUNT  = MAX_BUCKETS / 2;
    localparam int CNT_W       = 32;
    localparam int SUM_W       = 64;
    localparam int BOUND_W     = 32;
    localparam int IDX_W       = 3;
    localparam int CFG_IDX_W   = 4;
    localparam int BOUND_REGS  = 7;

    // Register index of the bounds-in-use register.
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDS_IN_USE = 4'd7;

    // Reset value of each bound register.
    localparam logic [BOUND_W-1:0] BOUND_RESET [BOUND_REGS] = '{
        32'd5000, 32'd10000, 32'd25000, 32'd50000,
        32'd100000, 32'd250000, 32'd500000
    };
    localparam logic [IDX_W-1:0] BOUNDS_IN_USE_RESET = 3'd7;

    // Request kind carried in tuser.
    typedef enum logic {
        REQ_OBSERVE = 1'b0,
        REQ_READ    = 1'b1
    } req_t;

    // Snapshot of the histogram taken for a read: pairwise bucket sums,
    // total count and running sum.
    typedef struct packed {
        logic [PART_COUNT-1:0][CNT_W-1:0] part;
        logic [CNT_W-1:0]                 total;
        logic [SUM_W-1:0]                 sum;
    } snap_t;

    // Addition that sticks at the all-ones value.
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

/* rtl/core/bhist_bucket_sel.sv */
// ============================================================================
// Bucket selector
// Finds the first bucket in use whose upper bound is at least the sample,
// or the overflow bucket just past the bounds in use.
// ============================================================================
module bhist_bucket_sel
    import bhist_pkg::*;
#(
    parameter int NUM_BOUNDS = 7
) (
    input  logic [BOUND_W-1:0] sample,
    input  logic [BOUND_W-1:0] bounds [NUM_BOUNDS],
    input  logic [IDX_W-1:0]   used,
    output logic [IDX_W-1:0]   idx
);

    // All bounds are compared at once; the lowest index that matches wins.
    always_comb begin
        idx = used;
        for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
            if ((IDX_W'(i) < used) && (sample <= bounds[i])) begin
                idx = IDX_W'(i);
            end
        end
    end

endmodule

/* rtl/core/bhist_counters.sv */
// ============================================================================
// Histogram counter bank
// Holds the bucket counts, total count and running sum, and takes the
// first level of the cumulative sum into a snapshot register for reads.
// ============================================================================
module bhist_counters
    import bhist_pkg::*;
#(
    parameter int NUM_BOUNDS = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               obs_en,
    input  logic [IDX_W-1:0]   obs_idx,
    input  logic [BOUND_W-1:0] obs_sample,
    input  logic               snap_en,
    input  logic [IDX_W-1:0]   snap_last,
    output snap_t              snap
);

    localparam int NB = NUM_BOUNDS + 1;

    logic [CNT_W-1:0] cnt_reg [NB];
    logic [CNT_W-1:0] total_reg;
    logic [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0] cnt_pad [MAX_BUCKETS];
    snap_t            snap_reg;
    snap_t            snap_next;

    // Bucket counters: the selected bucket counts up and sticks at full scale.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < NB; i++) begin
            if (!aresetn) begin
                cnt_reg[i] <= '0;
            end else if (obs_en && (obs_idx == IDX_W'(i))) begin
                cnt_reg[i] <= sat_add(cnt_reg[i], CNT_W'(1));
            end
        end
    end

    // Total count and wrapping sum of samples.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            sum_reg   <= '0;
        end else if (obs_en) begin
            total_reg <= sat_add(total_reg, CNT_W'(1));
            sum_reg   <= sum_reg + {{(SUM_W - BOUND_W){1'b0}}, obs_sample};
        end
    end

    // Pad the bucket row out to the full width of the adder tree.
    for (genvar g = 0; g < MAX_BUCKETS; g++) begin : g_pad
        if (g < NB) begin : g_used
            assign cnt_pad[g] = cnt_reg[g];
        end else begin : g_unused
            assign cnt_pad[g] = '0;
        end
    end

    // Keep only the buckets up to the last one asked for, then add in pairs.
    always_comb begin
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        for (int j = 0; j < PART_COUNT; j++) begin
            lo = (IDX_W'(2 * j) <= snap_last) ? cnt_pad[2 * j] : '0;
            hi = (IDX_W'(2 * j + 1) <= snap_last) ? cnt_pad[2 * j + 1] : '0;
            snap_next.part[j] = sat_add(lo, hi);
        end
        snap_next.total = total_reg;
        snap_next.sum   = sum_reg;
    end

    always_ff @(posedge aclk) begin
        if (snap_en) begin
            snap_reg <= snap_next;
        end
    end

    assign snap = snap_reg;

endmodule

/* rtl/core/bhist_sum_tree.sv */
// ============================================================================
// Cumulative sum tree and result register
// Adds the pairwise sums of a snapshot and holds the result beat until the
// downstream side takes it.
// ============================================================================
module bhist_sum_tree
    import bhist_pkg::*;
(
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    input  snap_t                           in_snap,
    output logic                            in_ready,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [2*CNT_W+SUM_W-1:0]        m_tdata
);

    logic                     valid_reg;
    logic [2*CNT_W+SUM_W-1:0] data_reg;
    logic [2*CNT_W+SUM_W-1:0] data_next;
    logic [CNT_W-1:0]         sum_lo;
    logic [CNT_W-1:0]         sum_hi;

    // Remaining two levels of the saturating tree.
    always_comb begin
        sum_lo    = sat_add(in_snap.part[0], in_snap.part[1]);
        sum_hi    = sat_add(in_snap.part[2], in_snap.part[3]);
        data_next = {in_snap.sum, in_snap.total, sat_add(sum_lo, sum_hi)};
    end

    assign in_ready = !valid_reg || m_tready;

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

/* rtl/core/bucketed_latency_histogram.sv */
// ============================================================================
// Bucketed latency histogram
// Cumulative bucket histogram with configurable upper bounds.
// ============================================================================
// The block takes one request beat per clock, observe or read, unless a read
// waits for the snapshot register. An observe beat is finished in the cycle
// after it is taken: the bounds are compared in parallel in the input stage
// and the chosen bucket, the total count and the 64-bit sum are updated
// there, so it gives no result. A read beat passes the input stage, a
// snapshot register holding pairwise bucket sums, and the result register
// after the last two levels of the saturating adder tree. Every read sees
// all observes taken before it. Counters stick at all ones, the sum wraps.
// The counters are cleared directly by reset; no clearing pass is needed.
// Configuration beats are always accepted and must only be sent while idle.
module bucketed_latency_histogram
    import bhist_pkg::*;
#(
    parameter int NUM_BOUNDS   = 7,
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Request channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,   // sample_value [31:0], read_bucket [34:32]
    input  logic [0:0]            s_tuser,   // req_type [0]
    // Result channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [127:0]          m_tdata,   // cumulative_count [31:0],
                                             // total_count [63:32], sample_sum [127:64]
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_data
);

    localparam logic [63:0] MASK_WIDE = (SAMPLE_WIDTH >= 64) ? {64{1'b1}}
                                      : ((64'd1 << SAMPLE_WIDTH) - 64'd1);
    localparam logic [BOUND_W-1:0] SAMPLE_MASK = MASK_WIDE[BOUND_W-1:0];
    localparam logic [IDX_W-1:0]   MAX_USED    = IDX_W'(NUM_BOUNDS);

    logic [BOUND_W-1:0] bound_reg [NUM_BOUNDS];
    logic [IDX_W-1:0]   biu_reg;
    logic [IDX_W-1:0]   used;

    logic               a_valid_reg;
    req_t               a_type_reg;
    logic [BOUND_W-1:0] a_sample_reg;
    logic [IDX_W-1:0]   a_bucket_reg;
    logic               a_fire;
    logic               a_obs_fire;
    logic               a_read_fire;
    logic [IDX_W-1:0]   a_idx;
    logic [IDX_W-1:0]   a_last;

    logic               p_valid_reg;
    logic               p_ready;
    logic               tree_ready;
    logic               p_ready_from_tree;
    snap_t              p_snap;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_BOUNDS; i++) begin
                bound_reg[i] <= BOUND_RESET[i];
            end
            biu_reg <= BOUNDS_IN_USE_RESET;
        end else if (cfg_valid) begin
            for (int i = 0; i < NUM_BOUNDS; i++) begin
                if (cfg_index == CFG_IDX_W'(i)) begin
                    bound_reg[i] <= cfg_data;
                end
            end
            if (cfg_index == CFG_BOUNDS_IN_USE) begin
                biu_reg <= cfg_data[IDX_W-1:0];
            end
        end
    end

    // A bounds count above the number built in is clamped.
    assign used = (biu_reg > MAX_USED) ? MAX_USED : biu_reg;

    // Input stage handshake: observes always leave, reads need the snapshot
    // register to be free.
    assign tree_ready  = p_ready_from_tree;
    assign p_ready     = !p_valid_reg || tree_ready;
    assign a_obs_fire  = a_valid_reg && (a_type_reg == REQ_OBSERVE);
    assign a_read_fire = a_valid_reg && (a_type_reg == REQ_READ) && p_ready;
    assign a_fire      = a_obs_fire || a_read_fire;
    assign s_tready    = !a_valid_reg || a_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tready) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            a_type_reg   <= req_t'(s_tuser[0]);
            a_sample_reg <= s_tdata[31:0] & SAMPLE_MASK;
            a_bucket_reg <= s_tdata[34:32];
        end
    end

    // A read at or past the bounds in use covers every bucket.
    assign a_last = (a_bucket_reg >= used) ? MAX_USED : a_bucket_reg;

    bhist_bucket_sel #(
        .NUM_BOUNDS (NUM_BOUNDS)
    ) u_bucket_sel (
        .sample (a_sample_reg),
        .bounds (bound_reg),
        .used   (used),
        .idx    (a_idx)
    );

    bhist_counters #(
        .NUM_BOUNDS (NUM_BOUNDS)
    ) u_counters (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .obs_en     (a_obs_fire),
        .obs_idx    (a_idx),
        .obs_sample (a_sample_reg),
        .snap_en    (a_read_fire),
        .snap_last  (a_last),
        .snap       (p_snap)
    );

    // Snapshot stage valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (a_read_fire) begin
            p_valid_reg <= 1'b1;
        end else if (tree_ready) begin
            p_valid_reg <= 1'b0;
        end
    end

    bhist_sum_tree u_sum_tree (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (p_valid_reg),
        .in_snap  (p_snap),
        .in_ready (p_ready_from_tree),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // An empty input stage always takes a new beat.
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !a_valid_reg |-> s_tready)
        else $error("input stage empty but not ready");

    // An observe never stalls in the input stage.
    a_obs_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (a_valid_reg && (a_type_reg == REQ_OBSERVE)) |-> s_tready)
        else $error("observe held in input stage");

    // A read leaving the input stage lands in the snapshot stage.
    a_read_snap: assert property (@(posedge aclk) disable iff (!aresetn)
        a_read_fire |=> p_valid_reg)
        else $error("read lost between input and snapshot stage");

    // A new result only appears after a snapshot was waiting.
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(p_valid_reg))
        else $error("result without snapshot");

endmodule

/* test/bucketed_latency_histogram_test.sv */
`timescale 1ns / 100ps
// ============================================================================
// Bucketed latency histogram testbench
// Drives observe and read request beats into the histogram under random
// stalls on both channels. A read result is predicted for every accepted read
// beat from a local copy of the bucket counts, the total and the sum. Each
// result beat is then compared field by field in arrival order. The run
// steps through several bound settings, including all-zero and all-ones
// bounds, unordered bounds, no bounds in use and writes to unmapped indexes.
// ============================================================================
module bucketed_latency_histogram_test;
    import bhist_pkg::*;

    localparam int NUM_BOUNDS   = 7;
    localparam int SETTLE_TICKS = 8;
    localparam int MAX_REPORTS  = 10;

    // Register indexes with no register behind them.
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNMAPPED = 4'd8;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNMAPPED  = 4'd15;

    // Shapes of bound setting visited by the random part.
    typedef enum int {
        SHAPE_ALL_ZERO,
        SHAPE_ALL_ONES,
        SHAPE_WIDE_ASCENDING,
        SHAPE_SINGLE_BOUND,
        SHAPE_SCRAMBLED,
        SHAPE_TIGHT_ASCENDING,
        SHAPE_COUNT
    } bound_shape_t;

    typedef struct packed {
        logic [CNT_W-1:0] cumulative;
        logic [CNT_W-1:0] total;
        logic [SUM_W-1:0] sum;
    } read_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [39:0]          s_tdata;   // sample_value [31:0], read_bucket [34:32]
    logic [0:0]           s_tuser;   // req_type [0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [127:0]         m_tdata;   // cumulative_count [31:0], total_count [63:32],
                                     // sample_sum [127:64]
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;

    // Local copy of the histogram state and its configuration.
    logic [BOUND_W-1:0] bound_copy [BOUND_REGS];
    logic [IDX_W-1:0]   in_use_copy;
    logic [CNT_W-1:0]   bucket_copy [NUM_BOUNDS+1];
    logic [CNT_W-1:0]   total_copy;
    logic [SUM_W-1:0]   sum_copy;
    logic [BOUND_W-1:0] next_bounds [BOUND_REGS];

    read_result_t pending_reads [$];

    bit          gaps_on;
    bit          stall_on;
    int unsigned result_hold_req;
    int unsigned mismatch_count;
    int unsigned requests_sent;
    int unsigned reads_checked;
    int unsigned settings_loaded;

    bucketed_latency_histogram #(
        .NUM_BOUNDS   (NUM_BOUNDS),
        .SAMPLE_WIDTH (32)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // Counter addition that sticks at all ones.
    function automatic logic [CNT_W-1:0] clamp_add(input logic [CNT_W-1:0] a,
                                                   input logic [CNT_W-1:0] b);
        logic [CNT_W:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        return wide[CNT_W] ? '1 : wide[CNT_W-1:0];
    endfunction

    function automatic int unsigned active_bounds();
        return (in_use_copy > NUM_BOUNDS) ? NUM_BOUNDS : in_use_copy;
    endfunction

    task automatic clear_histogram_copy();
        for (int i = 0; i < BOUND_REGS; i++) bound_copy[i] = BOUND_RESET[i];
        in_use_copy = BOUNDS_IN_USE_RESET;
        for (int i = 0; i <= NUM_BOUNDS; i++) bucket_copy[i] = '0;
        total_copy = '0;
        sum_copy   = '0;
    endtask

    // Update the local histogram for one accepted beat; a read queues the
    // result it must produce.
    task automatic tally_request(input req_t kind, input logic [31:0] sample,
                                 input logic [IDX_W-1:0] bucket);
        int unsigned  used;
        int unsigned  slot;
        int unsigned  last;
        read_result_t want;
        used = active_bounds();
        if (kind == REQ_OBSERVE) begin
            sum_copy   = sum_copy + {32'd0, sample};
            total_copy = clamp_add(total_copy, 1);
            slot = 0;
            while (slot < used && sample > bound_copy[slot]) slot++;
            bucket_copy[slot] = clamp_add(bucket_copy[slot], 1);
        end else begin
            last = (bucket >= used) ? NUM_BOUNDS : bucket;
            want.cumulative = '0;
            for (int i = 0; i <= last; i++)
                want.cumulative = clamp_add(want.cumulative, bucket_copy[i]);
            want.total = total_copy;
            want.sum   = sum_copy;
            pending_reads.push_back(want);
        end
    endtask

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] %s mismatch: expected %0h, got %0h", $time, field, want, got);
    endtask

    // Gap length: mostly none or short, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // Samples cluster around the bound registers, with full-range noise.
    function automatic logic [31:0] pick_sample();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return bound_copy[$urandom_range(0, BOUND_REGS - 1)]
                   + 32'($urandom_range(0, 2)) - 32'd1;
        if (r < 7) return $urandom;
        if (r == 7) return $urandom_range(0, 600000);
        if (r == 8) return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return 32'd1 << $urandom_range(0, 31);
    endfunction

    // Send one request beat, with an optional idle gap in front of it.
    task automatic send_request(input req_t kind, input logic [31:0] sample,
                                input logic [IDX_W-1:0] bucket);
        int unsigned idle;
        idle = gaps_on ? pick_gap() : 0;
        if (idle != 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, bucket, sample};
        s_tuser  <= kind;
        do @(posedge aclk); while (!s_tready);
        tally_request(kind, sample, bucket);
        requests_sent++;
    endtask

    // Stop sending and wait until every pending read has returned.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_reads.size() != 0);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] index, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (index < BOUND_REGS)
            bound_copy[index[IDX_W-1:0]] = value;
        else if (index == CFG_BOUNDS_IN_USE)
            in_use_copy = value[IDX_W-1:0];
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Drain, let observes finish, then write all bounds and the count in use.
    task automatic load_bounds(input logic [IDX_W-1:0] used);
        wait_drained();
        repeat (SETTLE_TICKS) @(posedge aclk);
        for (int i = 0; i < BOUND_REGS; i++)
            cfg_write(CFG_IDX_W'(i), next_bounds[i]);
        cfg_write(CFG_BOUNDS_IN_USE, 32'(used));
        settings_loaded++;
    endtask

    task automatic fill_ascending(input int unsigned step_max);
        logic [63:0] acc;
        acc = $urandom_range(0, step_max);
        for (int i = 0; i < BOUND_REGS; i++) begin
            next_bounds[i] = (acc > 64'hFFFF_FFFF) ? '1 : acc[31:0];
            acc = acc + $urandom_range(0, step_max);
        end
    endtask

    // Result side: random stalls, or a long hold when one is requested.
    initial begin
        int unsigned n;
        m_tready = 1'b0;
        forever begin
            n = 0;
            if (result_hold_req != 0) begin
                n = result_hold_req;
                result_hold_req = 0;
            end else if (stall_on) begin
                n = pick_gap();
            end
            if (n != 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    // Compare every result beat with the oldest pending read.
    always @(posedge aclk) begin
        read_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_reads.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] result beat %0h with no read pending", $time, m_tdata);
            end else begin
                want = pending_reads.pop_front();
                reads_checked++;
                if (m_tdata[31:0] !== want.cumulative)
                    note_mismatch("cumulative_count", 64'(want.cumulative), 64'(m_tdata[31:0]));
                if (m_tdata[63:32] !== want.total)
                    note_mismatch("total_count", 64'(want.total), 64'(m_tdata[63:32]));
                if (m_tdata[127:64] !== want.sum)
                    note_mismatch("sample_sum", want.sum, m_tdata[127:64]);
            end
        end
    end

    // Freshly reset histogram reads as empty.
    task automatic test_reset_state();
        send_request(REQ_READ, '0, 3'd0);
        send_request(REQ_READ, '1, 3'd7);
    endtask

    // Samples on, just past and far beyond the reset bounds.
    task automatic test_bucket_edges();
        send_request(REQ_OBSERVE, 32'd0, 3'd0);
        send_request(REQ_OBSERVE, 32'd5000, 3'd0);
        send_request(REQ_OBSERVE, 32'd5001, 3'd0);
        send_request(REQ_OBSERVE, 32'd500000, 3'd0);
        send_request(REQ_OBSERVE, 32'd500001, 3'd0);
        send_request(REQ_OBSERVE, 32'hFFFF_FFFF, 3'd7);
        send_request(REQ_READ, '0, 3'd0);
        send_request(REQ_READ, '0, 3'd1);
        send_request(REQ_READ, '0, 3'd6);
        send_request(REQ_READ, '0, 3'd7);
    endtask

    // With no bounds in use everything lands in bucket zero, and any read
    // sums all buckets, old counts included.
    task automatic test_no_bounds();
        wait_drained();
        repeat (SETTLE_TICKS) @(posedge aclk);
        cfg_write(CFG_BOUNDS_IN_USE, 32'd0);
        send_request(REQ_OBSERVE, 32'd123, 3'd0);
        send_request(REQ_OBSERVE, 32'hFFFF_FFFF, 3'd0);
        send_request(REQ_READ, '0, 3'd0);
        send_request(REQ_READ, '0, 3'd3);
    endtask

    // Unordered bounds: the first bound in index order that holds wins.
    task automatic test_unordered_bounds();
        next_bounds = '{32'd900, 32'd100, 32'd100, 32'd50000, 32'd10, 32'd0, 32'hFFFF_FFFF};
        load_bounds(3'd7);
        send_request(REQ_OBSERVE, 32'd100, 3'd0);
        send_request(REQ_OBSERVE, 32'd1000, 3'd0);
        send_request(REQ_OBSERVE, 32'd60000, 3'd0);
        send_request(REQ_READ, '0, 3'd2);
        send_request(REQ_READ, '0, 3'd7);
    endtask

    // Writes to unmapped indexes must leave every register alone.
    task automatic test_unmapped_index();
        wait_drained();
        repeat (SETTLE_TICKS) @(posedge aclk);
        cfg_write(CFG_FIRST_UNMAPPED, 32'd0);
        cfg_write(CFG_LAST_UNMAPPED, 32'h0000_0001);
        send_request(REQ_OBSERVE, 32'd5, 3'd0);
        send_request(REQ_READ, '0, 3'd0);
    endtask

    // Hold the result side for a long stretch while reads keep coming, then
    // pause the sender until everything is back.
    task automatic test_result_backpressure();
        gaps_on = 1'b0;
        result_hold_req = 250;
        for (int i = 0; i < 24; i++)
            send_request(REQ_READ, $urandom, IDX_W'($urandom_range(0, 7)));
        wait_drained();
        gaps_on = 1'b1;
    endtask

    task automatic run_traffic(input int unsigned items);
        req_t kind;
        for (int unsigned k = 0; k < items; k++) begin
            // Change the idling mode now and then, leaving some clean stretches.
            if (k % 40 == 0) begin
                gaps_on  = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 149) == 0) wait_drained();
            if ($urandom_range(0, 99) < 30)
                kind = REQ_READ;
            else
                kind = REQ_OBSERVE;
            send_request(kind, pick_sample(), IDX_W'($urandom_range(0, 7)));
        end
    endtask

    // Random traffic under a series of bound settings, extremes first.
    task automatic test_random_settings();
        bound_shape_t shape;
        logic [IDX_W-1:0] used;
        for (int s = 0; s < SHAPE_COUNT; s++) begin
            shape = bound_shape_t'(s);
            used  = 3'd7;
            case (shape)
                SHAPE_ALL_ZERO: begin
                    for (int i = 0; i < BOUND_REGS; i++) next_bounds[i] = '0;
                end
                SHAPE_ALL_ONES: begin
                    for (int i = 0; i < BOUND_REGS; i++) next_bounds[i] = '1;
                end
                SHAPE_WIDE_ASCENDING: fill_ascending(32'h1000_0000);
                SHAPE_SINGLE_BOUND: begin
                    fill_ascending(32'h1000_0000);
                    used = 3'd1;
                end
                SHAPE_SCRAMBLED: begin
                    for (int i = 0; i < BOUND_REGS; i++) next_bounds[i] = $urandom;
                    used = IDX_W'($urandom_range(0, 7));
                end
                default: begin
                    fill_ascending(64);
                    used = IDX_W'($urandom_range(2, 6));
                end
            endcase
            load_bounds(used);
            run_traffic(150);
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        gaps_on   = 1'b1;
        stall_on  = 1'b1;
        result_hold_req = 0;
        mismatch_count  = 0;
        requests_sent   = 0;
        reads_checked   = 0;
        settings_loaded = 0;
        clear_histogram_copy();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_bucket_edges();
        test_no_bounds();
        test_unordered_bounds();
        test_unmapped_index();
        test_result_backpressure();
        test_random_settings();

        wait_drained();
        repeat (16) @(posedge aclk);
        if (pending_reads.size() != 0) begin
            mismatch_count++;
            $display("%0d reads never returned a result", pending_reads.size());
        end

        $display("Sent %0d request beats and checked %0d read results over %0d bound settings,",
                 requests_sent, reads_checked, settings_loaded);
        $display("with unordered and empty bound lists, unmapped writes and a long result hold.");
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
